// ===== rtl/core/mm_pkg.sv =====
// Shared types and codes for the matrix multiply engine.
`timescale 1ns / 1ps
`default_nettype none
package mm_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

	localparam logic [1:0] CMD_WR_A = 2'd0;
	localparam logic [1:0] CMD_WR_B = 2'd1;
	localparam logic [1:0] CMD_MUL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef struct packed {
		logic load;
		logic last;
		logic err;
	} emit_t;

endpackage
`default_nettype wire

// ===== rtl/core/mm_store.sv =====
// Element store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mm_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/mm_mac.sv =====
// Multiply-accumulate pipeline fed by the two element stores.
`timescale 1ns / 1ps
`default_nettype none
module mm_mac #(
	parameter int ELEM_BITS = 16,
	parameter int PROD_W    = 35
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mm_pkg::mac_ctl_t            issue,
	input  wire logic signed [ELEM_BITS-1:0] a_rd,
	input  wire logic signed [ELEM_BITS-1:0] b_rd,
	output logic                             acc_done,
	output logic signed [PROD_W-1:0]         acc_q
);

	import mm_pkg::*;

	mac_ctl_t                      ctl_s1, ctl_s2;
	logic signed [2*ELEM_BITS-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd * b_rd;
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_q <= PROD_W'(prod_s2);
			end else begin
				acc_q <= acc_q + PROD_W'(prod_s2);
			end
		end
	end

	assign acc_done = ctl_s2.vld && ctl_s2.last;

endmodule
`default_nettype wire

// ===== rtl/core/mm_seq.sv =====
// Sequencer: walks i, j, k over the product and paces result loads.
`timescale 1ns / 1ps
`default_nettype none
module mm_seq #(
	parameter int MAX_DIM = 8,
	parameter int IDX_W   = 3,
	parameter int DIM_W   = 4,
	parameter int AW      = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIM_W-1:0] a_rows,
	input  wire logic [DIM_W-1:0] a_cols,
	input  wire logic [DIM_W-1:0] b_rows,
	input  wire logic [DIM_W-1:0] b_cols,
	input  wire logic             out_free,
	input  wire logic             acc_done,
	output logic                  idle,
	output logic [AW-1:0]         a_addr,
	output logic [AW-1:0]         b_addr,
	output mm_pkg::mac_ctl_t      issue,
	output mm_pkg::emit_t         emit,
	output logic [IDX_W-1:0]      out_row,
	output logic [IDX_W-1:0]      out_col
);

	import mm_pkg::*;

	seq_state_t       state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             err_q;
	logic [IDX_W-1:0] ar_last, ac_last, br_last, bc_last;
	logic             mismatch, k_end, j_end, i_end;

	// size 0 counts as 1, sizes above MAX_DIM count as MAX_DIM
	function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
		if (d == '0) begin
			return '0;
		end
		if (d > DIM_W'(MAX_DIM)) begin
			return IDX_W'(MAX_DIM - 1);
		end
		return IDX_W'(d - 1'b1);
	endfunction

	assign ar_last  = last_idx(a_rows);
	assign ac_last  = last_idx(a_cols);
	assign br_last  = last_idx(b_rows);
	assign bc_last  = last_idx(b_cols);
	assign mismatch = (ac_last != br_last);
	assign k_end    = (k_q == ac_last);
	assign j_end    = (j_q == bc_last);
	assign i_end    = (i_q == ar_last);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = mismatch ? ST_EMIT : ST_RUN;
			end
			ST_RUN: begin
				if (k_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (acc_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (err_q || (i_end && j_end)) ? ST_IDLE : ST_RUN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		idle        = (state_q == ST_IDLE);
		issue.vld   = (state_q == ST_RUN);
		issue.first = (k_q == '0);
		issue.last  = k_end;
		emit.load   = (state_q == ST_EMIT) && out_free;
		emit.err    = err_q;
		emit.last   = err_q || (i_end && j_end);
		a_addr      = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
		b_addr      = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);
		out_row     = i_q;
		out_col     = j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_START: begin
					i_q   <= '0;
					j_q   <= '0;
					k_q   <= '0;
					err_q <= mismatch;
				end
				ST_RUN: begin
					if (!k_end) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						k_q <= '0;
						if (j_end) begin
							j_q <= '0;
							if (!i_end) begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/matrix_multiply_top.sv =====
// Top level of the dense matrix multiply engine.
// Items with tuser 0 or 1 write one element of A or B at (row, col), back to back while idle;
// a write outside MAX_DIM x MAX_DIM is dropped. Tuser 2 computes C = A x B over the sizes in
// the size registers (0 counts as 1, above MAX_DIM counts as MAX_DIM) and streams C in
// row-major order with tlast on the final element. Each element of C goes through the single
// multiply-accumulate pipeline (one read port per store, read, multiply, accumulate), and a
// compute ends when its last result is loaded for output, so it is lengthened by any
// output stall; no input is accepted meanwhile. On an inner size mismatch a single result with
// tuser (error) and tlast set and zero data is sent. Elements read before being written
// give undefined products. Size registers may only be written while the engine is idle.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_top #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16,
	localparam int IDX_W    = $clog2(MAX_DIM),
	localparam int DIM_W    = $clog2(MAX_DIM + 1),
	localparam int PROD_W   = 2 * ELEM_BITS + IDX_W,
	localparam int IN_DW    = ((2 * IDX_W + ELEM_BITS + 7) / 8) * 8,
	localparam int OUT_DW   = ((2 * IDX_W + PROD_W + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [DIM_W-1:0]               cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [IN_DW-1:0]               s_tdata,   // row, col, value
	input  wire logic [1:0]                     s_tuser,   // cmd
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [OUT_DW-1:0]                   m_tdata,   // out_row, out_col, product
	output logic                                m_tlast,
	output logic                                m_tuser    // error
);

	import mm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [DIM_W-1:0]            a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [IDX_W-1:0]            in_row, in_col;
	logic [ELEM_BITS-1:0]        in_value;
	logic                        in_xfer, in_ok, we_a, we_b, start;
	logic [AW-1:0]               wr_addr, a_addr, b_addr;
	logic [ELEM_BITS-1:0]        a_rd, b_rd;
	logic                        idle, out_free, acc_done;
	mac_ctl_t                    issue;
	emit_t                       emit;
	logic [IDX_W-1:0]            seq_row, seq_col;
	logic signed [PROD_W-1:0]    acc;
	logic [IDX_W-1:0]            row_q, col_q;
	logic [PROD_W-1:0]           prod_q;
	logic                        vld_q, last_q, err_q;

	assign in_row   = s_tdata[IDX_W-1:0];
	assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_tdata[2*IDX_W+ELEM_BITS-1:2*IDX_W];

	assign s_tready = idle;
	assign in_xfer  = s_tvalid && s_tready;
	assign in_ok    = ({1'b0, in_row} < (IDX_W+1)'(MAX_DIM))
	               && ({1'b0, in_col} < (IDX_W+1)'(MAX_DIM));
	assign we_a     = in_xfer && (s_tuser == CMD_WR_A) && in_ok;
	assign we_b     = in_xfer && (s_tuser == CMD_WR_B) && in_ok;
	assign start    = in_xfer && (s_tuser == CMD_MUL);
	assign wr_addr  = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(MAX_DIM);
			a_cols_q <= DIM_W'(MAX_DIM);
			b_rows_q <= DIM_W'(MAX_DIM);
			b_cols_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_A_ROWS: a_rows_q <= cfg_data;
				CFG_A_COLS: a_cols_q <= cfg_data;
				CFG_B_ROWS: b_rows_q <= cfg_data;
				CFG_B_COLS: b_cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// writes only happen while idle, so reads of a compute always see them
	mm_store #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS), .AW(AW)) u_store_a (
		.clk       (clk),
		.we        (we_a),
		.wr_addr   (wr_addr),
		.wr_data   (in_value),
		.rd_addr   (a_addr),
		.rd_data_q (a_rd)
	);

	mm_store #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS), .AW(AW)) u_store_b (
		.clk       (clk),
		.we        (we_b),
		.wr_addr   (wr_addr),
		.wr_data   (in_value),
		.rd_addr   (b_addr),
		.rd_data_q (b_rd)
	);

	mm_seq #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W), .DIM_W(DIM_W), .AW(AW)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.a_rows   (a_rows_q),
		.a_cols   (a_cols_q),
		.b_rows   (b_rows_q),
		.b_cols   (b_cols_q),
		.out_free (out_free),
		.acc_done (acc_done),
		.idle     (idle),
		.a_addr   (a_addr),
		.b_addr   (b_addr),
		.issue    (issue),
		.emit     (emit),
		.out_row  (seq_row),
		.out_col  (seq_col)
	);

	mm_mac #(.ELEM_BITS(ELEM_BITS), .PROD_W(PROD_W)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.a_rd     (a_rd),
		.b_rd     (b_rd),
		.acc_done (acc_done),
		.acc_q    (acc)
	);

	assign out_free = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (emit.load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			row_q  <= seq_row;
			col_q  <= seq_col;
			prod_q <= emit.err ? '0 : acc;
			last_q <= emit.last;
			err_q  <= emit.err;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = OUT_DW'({prod_q, col_q, row_q});
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule
`default_nettype wire
